// ===== hdl/apc_pkg.sv =====
`default_nettype none

package apc_pkg;

  // fixed field widths of the transactions
  localparam int FIELD_W = 16;
  localparam int RESULT_SUM_W = 18;
  localparam int VALUE_WIDTH_DEFAULT = 16;

  typedef struct packed {
    logic [FIELD_W-1:0] value_a;
    logic [FIELD_W-1:0] value_b;
  } pair_t;

  typedef struct packed {
    logic                    is_amicable;
    logic [RESULT_SUM_W-1:0] divisor_sum_a;
    logic [RESULT_SUM_W-1:0] divisor_sum_b;
  } result_t;

  // microcode fields
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INIT,
    OP_SET_ONE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_NOP,
    OP_ADD_D,
    OP_ADD_Q,
    OP_STORE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SMALL,
    COND_DIV_BUSY,
    COND_QUO_LT_D,
    COND_SEL_A,
    COND_OUT_BUSY
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // program addresses
  localparam step_t STEP_LOAD      = 4'd0;
  localparam step_t STEP_INIT      = 4'd1;
  localparam step_t STEP_SET_ONE   = 4'd2;
  localparam step_t STEP_DIV_START = 4'd3;
  localparam step_t STEP_DIV_STEP  = 4'd4;
  localparam step_t STEP_TEST      = 4'd5;
  localparam step_t STEP_ADD_D     = 4'd6;
  localparam step_t STEP_ADD_Q     = 4'd7;
  localparam step_t STEP_STORE     = 4'd8;
  localparam step_t STEP_EMIT      = 4'd9;
  localparam step_t STEP_RETURN    = 4'd10;

  // control store: a jump is taken when its condition holds, else fall through
  function automatic ctrl_t ucode_rom(input step_t addr);
    ctrl_t w;
    unique case (addr)
      STEP_LOAD:      w = '{op: OP_LOAD,      cond: COND_NO_INPUT, target: STEP_LOAD};
      STEP_INIT:      w = '{op: OP_INIT,      cond: COND_SMALL,    target: STEP_STORE};
      STEP_SET_ONE:   w = '{op: OP_SET_ONE,   cond: COND_NEVER,    target: STEP_LOAD};
      STEP_DIV_START: w = '{op: OP_DIV_START, cond: COND_NEVER,    target: STEP_LOAD};
      STEP_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: COND_DIV_BUSY, target: STEP_DIV_STEP};
      STEP_TEST:      w = '{op: OP_NOP,       cond: COND_QUO_LT_D, target: STEP_STORE};
      STEP_ADD_D:     w = '{op: OP_ADD_D,     cond: COND_NEVER,    target: STEP_LOAD};
      STEP_ADD_Q:     w = '{op: OP_ADD_Q,     cond: COND_ALWAYS,   target: STEP_DIV_START};
      STEP_STORE:     w = '{op: OP_STORE,     cond: COND_SEL_A,    target: STEP_INIT};
      STEP_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_RETURN:    w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_LOAD};
      default:        w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/amicable_pair_check.sv =====
// amicable pair checker
// pair channel (pair_valid, pair_stall, pair_data) carries value_a and value_b;
// result channel (result_valid, result_stall, result_data) returns one transaction
// per pair: is_amicable and both proper divisor sums (saturated to 18 bits).
// only the low VALUE_WIDTH bits of each input value are used.
// a microcoded sequencer steps a small datapath: trial divisors d = 2, 3, ...
// run while d <= n/d, each through a restoring divider that takes one quotient
// bit per cycle. operands 0 and 1 skip the trial loop. a pair runs both operands
// in turn, and the divider loop sets the time that a pair takes.
// one pair is in work at a time; pair_stall is low only at the load step.
// a finished result waits in the output register while the next pair is
// loaded and worked on; if result_stall stays high the sequencer holds at its
// emit step until the previous result is taken.
// reset (rst, synchronous) returns the sequencer to the load step and drops
// result_valid; no stored data needs clearing.
`default_nettype none

module amicable_pair_check
  import apc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pair_valid,
  output logic         pair_stall,
  input  wire pair_t   pair_data,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result_data
);

  localparam int W     = VALUE_WIDTH;
  localparam int SUM_W = VALUE_WIDTH + 3;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int EXT_W = (SUM_W > RESULT_SUM_W) ? SUM_W : RESULT_SUM_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  // sequencer and datapath registers
  step_t            step;
  logic             sel;
  logic [W-1:0]     a;
  logic [W-1:0]     b;
  logic [W-1:0]     n;
  logic [W-1:0]     d;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [CNT_W-1:0] div_cnt;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;

  ctrl_t            ctrl;
  logic [W-1:0]     n_pick;
  logic [W:0]       rem_sh;
  logic [W:0]       rem_diff;
  logic             div_ge;
  logic             out_busy;
  logic             jump;
  step_t            step_next;

  // saturate an exact sum to the result field width
  function automatic logic [RESULT_SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(s);
    if ((ext >> RESULT_SUM_W) != '0) begin
      return '1;
    end
    return ext[RESULT_SUM_W-1:0];
  endfunction

  assign ctrl       = ucode_rom(step);
  assign pair_stall = (step != STEP_LOAD);
  assign out_busy   = result_valid && result_stall;
  assign n_pick     = sel ? b : a;

  // one restoring divider bit
  assign rem_sh   = {rem, quo[W-1]};
  assign rem_diff = rem_sh - {1'b0, d};
  assign div_ge   = (rem_sh >= {1'b0, d});

  // branch condition select
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !pair_valid;
      COND_SMALL:    jump = (n_pick < W'(2));
      COND_DIV_BUSY: jump = (div_cnt != CNT_LAST);
      COND_QUO_LT_D: jump = (quo < d);
      COND_SEL_A:    jump = !sel;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step_t'(step + 1'b1);
  end

  // step counter, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_LOAD;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (result_valid && !result_stall && (ctrl.op != OP_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (pair_valid) begin
            a   <= W'(pair_data.value_a);
            b   <= W'(pair_data.value_b);
            sel <= 1'b0;
          end
        end
        OP_INIT: begin
          n   <= n_pick;
          sum <= '0;
          d   <= W'(2);
        end
        OP_SET_ONE: begin
          sum <= SUM_W'(1);
        end
        OP_DIV_START: begin
          rem     <= '0;
          quo     <= n;
          div_cnt <= '0;
        end
        OP_DIV_STEP: begin
          rem     <= div_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
          quo     <= {quo[W-2:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
        end
        OP_NOP: begin
        end
        OP_ADD_D: begin
          if (rem == '0) begin
            sum <= sum + SUM_W'(d);
          end
        end
        OP_ADD_Q: begin
          if ((rem == '0) && (quo != d)) begin
            sum <= sum + SUM_W'(quo);
          end
          d <= d + 1'b1;
        end
        OP_STORE: begin
          if (!sel) begin
            sum_a <= sum;
            sel   <= 1'b1;
          end else begin
            sum_b <= sum;
          end
        end
        OP_EMIT: begin
          if (!out_busy) begin
            result_valid              <= 1'b1;
            result_data.is_amicable   <= (SUM_W'(a) == sum_b) && (SUM_W'(b) == sum_a);
            result_data.divisor_sum_a <= sat_sum(sum_a);
            result_data.divisor_sum_b <= sat_sum(sum);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // a new result only appears right after the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(step) == STEP_EMIT)
    else $error("result raised outside emit step");

  // the remainder is reduced below the divisor when the trial is tested
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_TEST) |-> (rem < d))
    else $error("divider remainder not below divisor");

  // a division always starts from a cleared bit counter
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_DIV_START) |=> (div_cnt == '0) && (step == STEP_DIV_STEP))
    else $error("divider did not start cleanly");

  // both operands are done before the result is formed
  a_emit_sel: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EMIT) |-> sel)
    else $error("emit reached before second operand");

  // the step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_RETURN)
    else $error("step counter left the program");
`endif

endmodule

`default_nettype wire
